// ===== rtl/core/line_rasterizer_unit_assert.svh =====
// Assertion macros for the line rasterizer unit
`ifndef LINE_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line rasterizer check failed");
`define LR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line rasterizer check failed");
`else
`define LR_ASSERT_SAME(label, ante, cons)
`define LR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/lr_pkg.sv =====
// Shared types and constants for the line rasterizer unit
`timescale 1ns / 1ps
package lr_pkg;

   localparam int FIELD_BITS       = 6;
   localparam int ERR_BITS         = FIELD_BITS + 3;
   localparam int COORD_BITS_DEF   = 6;
   localparam int QUEUE_DEPTH_DEF  = 2;

   typedef logic [FIELD_BITS-1:0] coord_type;

   // classified line segment handed from front to walker
   typedef struct packed {
      logic      steep;
      logic      minor_down;
      coord_type maj_start;
      coord_type min_start;
      coord_type maj_end;
      coord_type minor_delta;
      coord_type major_delta;
   } seg_type;

endpackage

// ===== rtl/core/lr_front.sv =====
// Line request classifier: picks major axis, orders endpoints, computes deltas
`timescale 1ns / 1ps
module lr_front #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
   input  lr_pkg::coord_type start_x,
   input  lr_pkg::coord_type start_y,
   input  lr_pkg::coord_type end_x,
   input  lr_pkg::coord_type end_y,
   output lr_pkg::seg_type   seg_o
);

   localparam lr_pkg::coord_type COORD_MASK =
      lr_pkg::FIELD_BITS'((1 << COORD_BITS) - 1);

   lr_pkg::coord_type x0, y0, x1, y1, dx, dy;
   lr_pkg::coord_type maj, min, maj_end, min_end;
   logic              steep;

   always_comb begin
      x0 = start_x & COORD_MASK;
      y0 = start_y & COORD_MASK;
      x1 = end_x & COORD_MASK;
      y1 = end_y & COORD_MASK;
      dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
      dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);
      steep = !(dy < dx);
      if (steep) begin
         if (y0 > y1) begin
            maj = y1; min = x1; maj_end = y0; min_end = x0;
         end else begin
            maj = y0; min = x0; maj_end = y1; min_end = x1;
         end
      end else begin
         if (x0 > x1) begin
            maj = x1; min = y1; maj_end = x0; min_end = y0;
         end else begin
            maj = x0; min = y0; maj_end = x1; min_end = y1;
         end
      end
      seg_o.steep       = steep;
      seg_o.minor_down  = min_end < min;
      seg_o.maj_start   = maj;
      seg_o.min_start   = min;
      seg_o.maj_end     = maj_end;
      seg_o.minor_delta = (min_end > min) ? (min_end - min) : (min - min_end);
      seg_o.major_delta = maj_end - maj;
   end

endmodule

// ===== rtl/core/lr_queue.sv =====
// Short segment queue between classifier and walker
`timescale 1ns / 1ps
module lr_queue #(
   parameter int DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_i,
   input  lr_pkg::seg_type data_i,
   output logic            full_o,
   input  logic            pop_i,
   output lr_pkg::seg_type data_o,
   output logic            empty_o
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   lr_pkg::seg_type       mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full_o  = (count_ff == FULL_CNT);
   assign empty_o = (count_ff == '0);
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign data_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

endmodule

// ===== rtl/core/lr_walker.sv =====
// Bresenham walker: steps one pixel per cycle into the result register while the receiver takes them
`timescale 1ns / 1ps
`include "line_rasterizer_unit_assert.svh"
module lr_walker #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lr_pkg::seg_type   seg_i,
   input  logic              q_empty_i,
   output logic              q_pop_o,
   output logic              empty,
   input  logic              pop,
   output lr_pkg::coord_type pixel_x,
   output lr_pkg::coord_type pixel_y,
   output logic              last_pixel
);

   localparam int EB = lr_pkg::ERR_BITS;
   localparam lr_pkg::coord_type COORD_MASK =
      lr_pkg::FIELD_BITS'((1 << COORD_BITS) - 1);

   logic              busy_ff, busy_in;
   logic              steep_ff, steep_in, down_ff, down_in;
   lr_pkg::coord_type maj_ff, maj_in, min_ff, min_in, maj_end_ff, maj_end_in;
   lr_pkg::coord_type minor_ff, minor_in, major_ff, major_in;
   logic [EB-1:0]     err_ff, err_in;
   logic              out_valid_ff, out_valid_in, last_ff, last_in;
   lr_pkg::coord_type px_ff, px_in, py_ff, py_in;
   logic              out_free, at_last, err_pos;

   assign out_free = !out_valid_ff || pop;
   assign at_last  = (maj_ff == maj_end_ff);
   assign err_pos  = !err_ff[EB-1] && (err_ff != '0);
   assign q_pop_o  = !busy_ff && !q_empty_i;

   always_comb begin
      busy_in      = busy_ff;
      steep_in     = steep_ff;
      down_in      = down_ff;
      maj_in       = maj_ff;
      min_in       = min_ff;
      maj_end_in   = maj_end_ff;
      minor_in     = minor_ff;
      major_in     = major_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff && !pop;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      if (!busy_ff) begin
         if (!q_empty_i) begin
            busy_in    = 1'b1;
            steep_in   = seg_i.steep;
            down_in    = seg_i.minor_down;
            maj_in     = seg_i.maj_start;
            min_in     = seg_i.min_start;
            maj_end_in = seg_i.maj_end;
            minor_in   = seg_i.minor_delta;
            major_in   = seg_i.major_delta;
            err_in     = EB'({seg_i.minor_delta, 1'b0}) - EB'(seg_i.major_delta);
         end
      end else if (out_free) begin
         out_valid_in = 1'b1;
         px_in        = steep_ff ? min_ff : maj_ff;
         py_in        = steep_ff ? maj_ff : min_ff;
         last_in      = at_last;
         if (err_pos) begin
            min_in = (down_ff ? (min_ff - 1'b1) : (min_ff + 1'b1)) & COORD_MASK;
            err_in = err_ff + EB'({minor_ff, 1'b0}) - EB'({major_ff, 1'b0});
         end else begin
            err_in = err_ff + EB'({minor_ff, 1'b0});
         end
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            maj_in = (maj_ff + 1'b1) & COORD_MASK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff   <= steep_in;
      down_ff    <= down_in;
      maj_ff     <= maj_in;
      min_ff     <= min_in;
      maj_end_ff <= maj_end_in;
      minor_ff   <= minor_in;
      major_ff   <= major_in;
      err_ff     <= err_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      last_ff    <= last_in;
   end

   assign empty      = !out_valid_ff;
   assign pixel_x    = px_ff;
   assign pixel_y    = py_ff;
   assign last_pixel = last_ff;

   `LR_ASSERT_NEXT(a_last_ends_line, busy_ff && out_free && at_last, !busy_ff && last_pixel)
   `LR_ASSERT_SAME(a_load_when_idle, q_pop_o, !busy_ff)
   `LR_ASSERT_SAME(a_major_in_bounds, busy_ff, maj_ff <= maj_end_ff)
   `LR_ASSERT_SAME(a_err_upper, busy_ff, $signed(err_ff) <= $signed({2'b00, minor_ff, 1'b0}))

endmodule

// ===== rtl/core/line_rasterizer_unit.sv =====
// Top level of the line rasterizer unit
// Usage:
//   Line requests enter through a queue-style port: an item is taken at a
//   clock edge with push high and full low. Each item carries two endpoints.
//   Pixels leave through a queue-style port: while empty is low the oldest
//   pixel sits on rsp_pixel_x / rsp_pixel_y / rsp_last_pixel, and it is
//   taken at an edge with pop high. rsp_last_pixel marks a line's end.
//   The classifier writes each request into a two-entry segment queue; the
//   walker takes one segment, loads it, then produces one pixel per cycle
//   while the receiver takes them. A line has N pixels (N = major delta + 1,
//   at most 2**COORD_BITS); the first pixel passes through the segment queue,
//   the walker's load step and the result register. The walker's single
//   pixel step sets the rate.
//   A stalled receiver holds the walker; requests keep entering until the
//   segment queue fills, then full rises.
//   Synchronous reset empties the segment queue and the result register and
//   returns the walker to idle; no clearing pass is needed.
`timescale 1ns / 1ps
module line_rasterizer_unit #(
   parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lr_pkg::coord_type req_start_x,
   input  lr_pkg::coord_type req_start_y,
   input  lr_pkg::coord_type req_end_x,
   input  lr_pkg::coord_type req_end_y,
   output logic              empty,
   input  logic              pop,
   output lr_pkg::coord_type rsp_pixel_x,
   output lr_pkg::coord_type rsp_pixel_y,
   output logic              rsp_last_pixel
);

   lr_pkg::seg_type seg_in, seg_out;
   logic            q_empty, q_pop;

   lr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .seg_o   (seg_in)
   );

   lr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (seg_in),
      .full_o  (full),
      .pop_i   (q_pop),
      .data_o  (seg_out),
      .empty_o (q_empty)
   );

   lr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock      (clock),
      .reset      (reset),
      .seg_i      (seg_out),
      .q_empty_i  (q_empty),
      .q_pop_o    (q_pop),
      .empty      (empty),
      .pop        (pop),
      .pixel_x    (rsp_pixel_x),
      .pixel_y    (rsp_pixel_y),
      .last_pixel (rsp_last_pixel)
   );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Bresenham line rasterizer unit
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      lr_pkg::coord_type x;
      lr_pkg::coord_type y;
      logic              last;
   } pixel_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   lr_pkg::coord_type req_start_x = '0;
   lr_pkg::coord_type req_start_y = '0;
   lr_pkg::coord_type req_end_x = '0;
   lr_pkg::coord_type req_end_y = '0;
   logic              empty;
   logic              pop = 1'b0;
   lr_pkg::coord_type rsp_pixel_x;
   lr_pkg::coord_type rsp_pixel_y;
   logic              rsp_last_pixel;

   pixel_type pending_pixels[$];
   int        error_count = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;

   line_rasterizer_unit dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .empty(empty),
      .pop(pop),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_last_pixel(rsp_last_pixel)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < 50)
         $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Walks the line and queues every pixel it covers, major axis ascending.
   task automatic compute_line_pixels(input lr_pkg::coord_type sx, input lr_pkg::coord_type sy,
                                      input lr_pkg::coord_type ex, input lr_pkg::coord_type ey);
      lr_pkg::coord_type                  dx, dy, maj, mn, maj_last, mn_last, maj_span, mn_span;
      logic                               steep, down;
      logic signed [lr_pkg::ERR_BITS-1:0] err;
      pixel_type                          px;
      dx = (ex > sx) ? ex - sx : sx - ex;
      dy = (ey > sy) ? ey - sy : sy - ey;
      steep = !(dy < dx);
      if (steep) begin
         if (sy > ey) begin
            maj = ey; mn = ex; maj_last = sy; mn_last = sx;
         end else begin
            maj = sy; mn = sx; maj_last = ey; mn_last = ex;
         end
      end else begin
         if (sx > ex) begin
            maj = ex; mn = ey; maj_last = sx; mn_last = sy;
         end else begin
            maj = sx; mn = sy; maj_last = ex; mn_last = ey;
         end
      end
      maj_span = maj_last - maj;
      down = mn_last < mn;
      mn_span = down ? mn - mn_last : mn_last - mn;
      err = lr_pkg::ERR_BITS'(2 * $signed({3'b000, mn_span}) - $signed({3'b000, maj_span}));
      for (int n = 0; n < 64; n++) begin
         px.x = steep ? mn : maj;
         px.y = steep ? maj : mn;
         px.last = (maj == maj_last);
         pending_pixels.push_back(px);
         if (err > 0) begin
            mn = down ? mn - 1'b1 : mn + 1'b1;
            err = lr_pkg::ERR_BITS'(err + 2 * ($signed({3'b000, mn_span})
                                               - $signed({3'b000, maj_span})));
         end else begin
            err = lr_pkg::ERR_BITS'(err + 2 * $signed({3'b000, mn_span}));
         end
         if (px.last)
            break;
         maj = maj + 1'b1;
      end
   endtask

   task automatic send_line(input lr_pkg::coord_type sx, input lr_pkg::coord_type sy,
                            input lr_pkg::coord_type ex, input lr_pkg::coord_type ey);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      do
         @(posedge clock);
      while (full);
      compute_line_pixels(sx, sy, ex, ey);
   endtask

   always @(negedge clock) begin
      if (reset)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset && pop && !empty) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                      rsp_pixel_x, rsp_pixel_y, rsp_last_pixel));
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_pixel_x !== exp_px.x)
               report_mismatch($sformatf("pixel_x %0d, expected %0d", rsp_pixel_x, exp_px.x));
            if (rsp_pixel_y !== exp_px.y)
               report_mismatch($sformatf("pixel_y %0d, expected %0d", rsp_pixel_y, exp_px.y));
            if (rsp_last_pixel !== exp_px.last)
               report_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                         rsp_last_pixel, exp_px.last, exp_px.x, exp_px.y));
         end
      end
   end

   task automatic test_single_points();
      send_line(6'd0, 6'd0, 6'd0, 6'd0);
      send_line(6'd63, 6'd63, 6'd63, 6'd63);
      send_line(6'd21, 6'd42, 6'd21, 6'd42);
   endtask

   task automatic test_axis_lines();
      send_line(6'd0, 6'd0, 6'd63, 6'd0);
      send_line(6'd63, 6'd63, 6'd0, 6'd63);
      send_line(6'd0, 6'd63, 6'd0, 6'd0);
      send_line(6'd63, 6'd0, 6'd63, 6'd63);
      send_line(6'd10, 6'd5, 6'd11, 6'd5);
   endtask

   // equal deltas take the steep path
   task automatic test_diagonals();
      send_line(6'd0, 6'd0, 6'd63, 6'd63);
      send_line(6'd63, 6'd0, 6'd0, 6'd63);
      send_line(6'd63, 6'd63, 6'd0, 6'd0);
      send_line(6'd5, 6'd9, 6'd6, 6'd8);
   endtask

   task automatic test_octants();
      send_line(6'd0, 6'd0, 6'd63, 6'd20);
      send_line(6'd63, 6'd20, 6'd0, 6'd0);
      send_line(6'd0, 6'd63, 6'd63, 6'd40);
      send_line(6'd63, 6'd40, 6'd0, 6'd63);
      send_line(6'd0, 6'd0, 6'd20, 6'd63);
      send_line(6'd20, 6'd63, 6'd0, 6'd0);
      send_line(6'd63, 6'd0, 6'd40, 6'd63);
      send_line(6'd40, 6'd63, 6'd63, 6'd0);
      send_line(6'd0, 6'd0, 6'd63, 6'd62);
      send_line(6'd0, 6'd1, 6'd63, 6'd0);
      send_line(6'd30, 6'd31, 6'd33, 6'd29);
   endtask

   task automatic test_random_lines(input int count, input int send_pct, input int rsp_pct);
      lr_pkg::coord_type sx, sy, ex, ey, d;
      send_idle_pct = send_pct;
      rsp_stall_pct = rsp_pct;
      repeat (count) begin
         sx = 6'($urandom);
         sy = 6'($urandom);
         ex = 6'($urandom);
         ey = 6'($urandom);
         case ($urandom_range(9))
            4, 5, 6: begin
               ex = sx + 6'($urandom_range(14)) - 6'd7;
               ey = sy + 6'($urandom_range(14)) - 6'd7;
            end
            7: begin
               d = 6'($urandom_range(63));
               ex = $urandom_range(1) ? sx + d : sx - d;
               ey = $urandom_range(1) ? sy + d : sy - d;
            end
            8: begin
               if ($urandom_range(1))
                  ey = sy;
               else
                  ex = sx;
            end
            9: begin
               ex = sx;
               ey = sy;
            end
            default: ;
         endcase
         send_line(sx, sy, ex, ey);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_points();
      test_axis_lines();
      test_diagonals();
      test_octants();
      test_random_lines(50, 0, 0);
      test_random_lines(45, 74, 0);
      test_random_lines(45, 0, 74);
      test_random_lines(45, 16, 16);
      @(negedge clock);
      push <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #8ms;
      $display("testbench failed");
      $finish;
   end

endmodule
